// ===== sv/efb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types, codes and helpers for the escaped serial frame builder.
// ----------------------------------------------------------------------------
package efb_pkg;

  localparam int EFB_QUEUE_DEPTH = 2;
  localparam int EFB_CFG_IDX_W   = 2;

  typedef enum logic [EFB_CFG_IDX_W-1:0] {
    CFG_ESCAPE = 2'd0,
    CFG_START  = 2'd1,
    CFG_END    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
    logic       sequence_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0] escape_byte;
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_DATA  = 2'd1,
    JOB_ERROR = 2'd2
  } job_kind_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;       // command or payload byte
    logic [7:0] b1;       // length
    logic [7:0] chk;
    logic       stuff;
    logic       close;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_HDR_ESC = 4'd1,
    ST_START   = 4'd2,
    ST_CMD     = 4'd3,
    ST_LEN     = 4'd4,
    ST_STUFF   = 4'd5,
    ST_DATA    = 4'd6,
    ST_CHK     = 4'd7,
    ST_END_ESC = 4'd8,
    ST_END     = 4'd9,
    ST_ERR     = 4'd10
  } back_step_t;

  function automatic back_step_t first_step(input job_t j);
    back_step_t s;
    unique case (j.kind)
      JOB_START: s = ST_HDR_ESC;
      JOB_DATA:  s = j.stuff ? ST_STUFF : ST_DATA;
      default:   s = ST_ERR;
    endcase
    return s;
  endfunction

  function automatic back_step_t next_step(input back_step_t s);
    back_step_t n;
    unique case (s)
      ST_HDR_ESC: n = ST_START;
      ST_START:   n = ST_CMD;
      ST_CMD:     n = ST_LEN;
      ST_LEN:     n = ST_CHK;
      ST_STUFF:   n = ST_DATA;
      ST_DATA:    n = ST_CHK;
      ST_CHK:     n = ST_END_ESC;
      ST_END_ESC: n = ST_END;
      default:    n = ST_IDLE;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/efb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_front
// Accepts input transactions, tracks frame state and the running sum, and
// turns each transaction into a job for the back end.
// ----------------------------------------------------------------------------
module efb_front
  import efb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     job_push,
  output job_t     job,
  input  logic     job_full
);

  logic       frame_open;
  logic [7:0] bytes_remaining;
  logic [7:0] sum_accumulator;

  logic       frame_open_next;
  logic [7:0] bytes_remaining_next;
  logic [7:0] sum_accumulator_next;
  logic [7:0] start_sum;
  logic [7:0] data_sum;
  logic [7:0] remaining_dec;

  assign in_ready = !job_full;
  assign job_push = in_valid && in_ready;

  assign start_sum     = in_item.command_code + in_item.payload_length;
  assign data_sum      = sum_accumulator + in_item.payload_byte;
  assign remaining_dec = bytes_remaining - 8'd1;

  always_comb begin
    job                  = '0;
    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    sum_accumulator_next = sum_accumulator;
    if (!in_item.mode) begin
      job.kind             = JOB_START;
      job.b0               = in_item.command_code;
      job.b1               = in_item.payload_length;
      job.chk              = 8'd0 - start_sum;
      job.close            = (in_item.payload_length == 8'd0);
      sum_accumulator_next = start_sum;
      bytes_remaining_next = in_item.payload_length;
      frame_open_next      = (in_item.payload_length != 8'd0);
    end else if (!frame_open) begin
      job.kind = JOB_ERROR;
    end else begin
      job.kind             = JOB_DATA;
      job.b0               = in_item.payload_byte;
      job.chk              = 8'd0 - data_sum;
      job.stuff            = (in_item.payload_byte == cfg.escape_byte);
      job.close            = (remaining_dec == 8'd0);
      sum_accumulator_next = data_sum;
      bytes_remaining_next = remaining_dec;
      frame_open_next      = (remaining_dec != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= 8'd0;
      sum_accumulator <= 8'd0;
    end else if (job_push) begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
      sum_accumulator <= sum_accumulator_next;
    end
  end

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> bytes_remaining != 8'd0)
    else $error("open frame with no bytes remaining");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (job_push && job.kind == JOB_ERROR) |=> $stable(sum_accumulator) && !frame_open)
    else $error("error transaction changed frame state");

  a_close_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (job_push && job.close) |=> !frame_open)
    else $error("frame still open after close");

endmodule

// ===== sv/efb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_fifo
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module efb_fifo
  import efb_pkg::*;
#(
  parameter int DEPTH = EFB_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== sv/efb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efb_back
// Serializes jobs into framed bytes, one byte per cycle while the output is not
// stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module efb_back
  import efb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  back_step_t step;
  back_step_t step_next;
  job_t       cur;
  job_t       cur_next;
  out_item_t  emit;
  logic       out_load;
  logic       step_last;

  assign out_load = (step != ST_IDLE) && (!out_valid || out_ready);

  always_comb begin
    unique case (step)
      ST_LEN, ST_DATA: step_last = !cur.close;
      ST_END, ST_ERR:  step_last = 1'b1;
      default:         step_last = 1'b0;
    endcase
  end

  assign pop = q_valid && ((step == ST_IDLE) || (out_load && step_last));

  // next state
  always_comb begin
    step_next = step;
    cur_next  = cur;
    if (pop) begin
      step_next = first_step(q_job);
      cur_next  = q_job;
    end else if (out_load) begin
      step_next = step_last ? ST_IDLE : next_step(step);
    end
  end

  // outputs
  always_comb begin
    emit          = '0;
    emit.run_last = step_last;
    unique case (step)
      ST_HDR_ESC, ST_STUFF, ST_END_ESC: emit.out_byte = cfg.escape_byte;
      ST_START: emit.out_byte = cfg.start_byte;
      ST_CMD:   emit.out_byte = cur.b0;
      ST_LEN:   emit.out_byte = cur.b1;
      ST_DATA:  emit.out_byte = cur.b0;
      ST_CHK:   emit.out_byte = cur.chk;
      ST_END: begin
        emit.out_byte   = cfg.end_byte;
        emit.frame_done = 1'b1;
      end
      ST_ERR:   emit.sequence_error = 1'b1;
      default:  emit.out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (out_load) begin
      out_item <= emit;
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_done) |-> out_item.run_last)
    else $error("frame end byte not last of its transaction");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.sequence_error) |->
      (out_item.run_last && !out_item.frame_done && out_item.out_byte == 8'd0))
    else $error("malformed error result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_item))
    else $error("output changed while stalled");

endmodule

// ===== sv/escaped_serial_frame_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_serial_frame_builder
// Byte-stuffing serial framer with start/end markers and two's complement
// checksum.
// ----------------------------------------------------------------------------
// A start transaction (mode 0) produces escape, start, command and length,
// plus checksum, escape and end when the length is zero; a payload
// transaction produces its byte, preceded by an extra escape when it equals
// the escape byte, and checksum, escape and end after the last one. A payload
// transaction with no open frame produces a single error result. The front end
// takes one input transaction per cycle while its QUEUE_DEPTH-entry job queue
// has room; the back end emits one output byte per cycle while it has work and
// the output is not stalled, so an input transaction yields 1 to 7 output
// results (typically 1, or 2 for a stuffed byte), and the sustained rate is
// set by the number of bytes emitted.
// Configuration writes take effect at once and should be made while idle.
// ----------------------------------------------------------------------------
module escaped_serial_frame_builder
  import efb_pkg::*;
#(
  parameter int QUEUE_DEPTH = EFB_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [EFB_CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_item
);

  cfg_t cfg;
  logic job_push;
  job_t job;
  logic job_full;
  logic q_pop;
  logic q_valid;
  job_t q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_byte <= 8'd16;
      cfg.start_byte  <= 8'd2;
      cfg.end_byte    <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ESCAPE: cfg.escape_byte <= cfg_data;
        CFG_START:  cfg.start_byte  <= cfg_data;
        CFG_END:    cfg.end_byte    <= cfg_data;
        default:    ;
      endcase
    end
  end

  efb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .job_push (job_push),
    .job      (job),
    .job_full (job_full)
  );

  efb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .full     (job_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  efb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
